// ===== hw/rtl/fdcr_pkg.sv =====
// fdcr_pkg: types, constants and helper functions for the frame deviation cut rate detector
// used by the controller, datapath, top level and testbench; depends on nothing
package fdcr_pkg;

   localparam int SUM_W = 31;
   localparam int DEV_W = 31;
   localparam int CFG_W = 8;
   localparam int FIB_W = 6;
   localparam int CSR_ADDR_W = 2;
   localparam int ROOT_W = 64;

   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
   localparam logic [CFG_W-1:0] CUT_MAX = {CFG_W{1'b1}};

   localparam logic [CSR_ADDR_W-1:0] CFG_REPORT_PERIOD = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CFG_HIGH_CUT_LIMIT = 2'd1;
   localparam logic [CFG_W-1:0] REPORT_PERIOD_RST = 8'd15;
   localparam logic [CFG_W-1:0] HIGH_CUT_LIMIT_RST = 8'd5;

   localparam logic [31:0] POW10 [9] = '{
      32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000, 32'd1000000,
      32'd10000000, 32'd100000000, 32'd1000000000
   };

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic       last_of_frame;
      logic       last_of_batch;
   } req_type;

   typedef struct packed {
      logic [DEV_W-1:0] deviation;
      logic             cut_found;
      logic             report_valid;
      logic             high_cut_rate;
      logic [FIB_W-1:0] frames_in_batch;
      logic             batch_overflow;
   } rsp_type;

   typedef struct packed {
      logic pix;      // take a pixel
      logic chk;      // batch closed: arm mean divide
      logic step;     // one divider step
      logic mean_ld;  // latch mean, start square loop
      logic rd;       // issue frame sum read
      logic df;       // absolute difference
      logic mul;      // square
      logic acc;      // accumulate, advance index
      logic var_init; // arm variance divide
      logic var_ld;   // latch variance, start root
      logic root;     // one root step
      logic fin;      // publish result
   } cmd_type;

   typedef struct packed {
      logic small_n;
      logic div_done;
      logic loop_last;
      logic root_done;
      logic rsp_valid;
   } sts_type;

   // 1 for 0..9, up to 10
   function automatic logic [3:0] digit_count(input logic [DEV_W-1:0] x);
      logic [3:0] d;
      d = 4'd1;
      for (int k = 0; k < 9; k++) begin
         if ({1'b0, x} >= POW10[k]) d = d + 4'd1;
      end
      return d;
   endfunction

endpackage

// ===== hw/rtl/fdcr_ram.sv =====
// fdcr_ram: generic simple dual port ram, one write port, one registered read port
// no dependencies
module fdcr_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/fdcr_ctrl.sv =====
// fdcr_ctrl: sequencer for pixel intake and batch statistics
// depends on fdcr_pkg
module fdcr_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_last_of_batch,
   output logic              req_ready,
   input  fdcr_pkg::sts_type sts,
   output fdcr_pkg::cmd_type cmd
);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_CHK  = 4'd1;
   localparam logic [3:0] ST_MDIV = 4'd2;
   localparam logic [3:0] ST_RD   = 4'd3;
   localparam logic [3:0] ST_DF   = 4'd4;
   localparam logic [3:0] ST_MUL  = 4'd5;
   localparam logic [3:0] ST_ACC  = 4'd6;
   localparam logic [3:0] ST_VI   = 4'd7;
   localparam logic [3:0] ST_VDIV = 4'd8;
   localparam logic [3:0] ST_ROOT = 4'd9;
   localparam logic [3:0] ST_FIN  = 4'd10;

   logic [3:0] state_ff, state_in;

   // a batch end waits until the previous result is gone
   assign req_ready = (state_ff == ST_IDLE) && (!sts.rsp_valid || !req_last_of_batch);

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.pix = 1'b1;
               if (req_last_of_batch) state_in = ST_CHK;
            end
         end
         ST_CHK: begin
            cmd.chk = 1'b1;
            state_in = sts.small_n ? ST_FIN : ST_MDIV;
         end
         ST_MDIV: begin
            if (sts.div_done) begin
               cmd.mean_ld = 1'b1;
               state_in = ST_RD;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_RD: begin
            cmd.rd = 1'b1;
            state_in = ST_DF;
         end
         ST_DF: begin
            cmd.df = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc = 1'b1;
            state_in = sts.loop_last ? ST_VI : ST_RD;
         end
         ST_VI: begin
            cmd.var_init = 1'b1;
            state_in = ST_VDIV;
         end
         ST_VDIV: begin
            if (sts.div_done) begin
               cmd.var_ld = 1'b1;
               state_in = ST_ROOT;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_ROOT: begin
            if (sts.root_done) state_in = ST_FIN;
            else cmd.root = 1'b1;
         end
         ST_FIN: begin
            cmd.fin = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

endmodule

// ===== hw/rtl/fdcr_datapath.sv =====
// fdcr_datapath: frame sums, shared divider, square accumulator, root unit, cut logic
// depends on fdcr_pkg and fdcr_ram
module fdcr_datapath #(
   parameter int MAX_FRAMES = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  fdcr_pkg::req_type                   req_data,
   input  logic                                csr_wr_en,
   input  logic [fdcr_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [fdcr_pkg::CFG_W-1:0]          csr_wr_data,
   input  fdcr_pkg::cmd_type                   cmd,
   output fdcr_pkg::sts_type                   sts,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output fdcr_pkg::rsp_type                   rsp_data
);

   localparam int SUM_W = fdcr_pkg::SUM_W;
   localparam int CNT_W = $clog2(MAX_FRAMES + 1);
   localparam int AW = $clog2(MAX_FRAMES);
   localparam int TOT_W = SUM_W + CNT_W;
   localparam int SQ_W = 2 * SUM_W;
   localparam int ACC_W = SQ_W + CNT_W;
   localparam int DVS_W = CNT_W;
   localparam int DI_W = $clog2(ACC_W + 1);
   localparam int RW = fdcr_pkg::ROOT_W;
   localparam int CW = fdcr_pkg::CFG_W;

   logic [SUM_W-1:0] pix_acc_ff, pix_acc_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [TOT_W-1:0] total_ff, total_in;
   logic             ovf_ff, ovf_in;
   logic [CW-1:0]    period_ff, limit_ff;
   logic [SUM_W-1:0] prior_ff, prior_in;
   logic [CW-1:0]    cut_ff, cut_in;
   logic [CW-1:0]    bcnt_ff, bcnt_in;

   logic [ACC_W-1:0] num_ff;
   logic [DVS_W:0]   rem_ff;
   logic [DVS_W-1:0] dvs_ff;
   logic [DI_W-1:0]  div_i_ff;
   logic [SUM_W-1:0] mean_ff;
   logic [CNT_W-1:0] idx_ff;
   logic [SUM_W-1:0] diff_ff;
   logic [SQ_W-1:0]  sq_ff;
   logic [ACC_W-1:0] sq_acc_ff;
   logic [RW-1:0]    v_ff, r_ff, bit_ff;

   logic                rsp_valid_ff;
   fdcr_pkg::rsp_type   rsp_ff;

   // pixel path
   logic [9:0]       px;
   logic [SUM_W:0]   px_sum;
   logic [SUM_W-1:0] frame_sum;
   logic             frame_end, store_en;

   assign px = 10'(req_data.blue) + 10'(req_data.green) + 10'(req_data.red);
   assign px_sum = (SUM_W+1)'(pix_acc_ff) + (SUM_W+1)'(px);
   assign frame_sum = (px_sum > (SUM_W+1)'(fdcr_pkg::SUM_MAX)) ? fdcr_pkg::SUM_MAX
                                                               : px_sum[SUM_W-1:0];
   assign frame_end = req_data.last_of_frame || req_data.last_of_batch;
   assign store_en = cmd.pix && frame_end && (cnt_ff < CNT_W'(MAX_FRAMES));

   logic [SUM_W-1:0] ram_q;

   fdcr_ram #(.WIDTH(SUM_W), .DEPTH(MAX_FRAMES)) u_store (
      .clock   (clock),
      .wr_en   (store_en),
      .wr_addr (cnt_ff[AW-1:0]),
      .wr_data (frame_sum),
      .rd_en   (cmd.rd),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (ram_q)
   );

   // divider step
   logic [DVS_W:0] rem_sh;
   logic           q_bit;
   assign rem_sh = {rem_ff[DVS_W-1:0], num_ff[ACC_W-1]};
   assign q_bit = rem_sh >= {1'b0, dvs_ff};

   // root step
   logic [RW-1:0] r_plus;
   assign r_plus = r_ff + bit_ff;

   // finish logic
   logic [SUM_W-1:0] dev, dev_diff;
   logic [3:0]       d1, d2, d3, lim;
   logic             rep, high, cut;
   logic [CW-1:0]    cut_base;
   logic [CNT_W+5:0] cnt_ext;

   always_comb begin
      if (sts.small_n) dev = '0;
      else if (r_ff > RW'(fdcr_pkg::SUM_MAX)) dev = fdcr_pkg::SUM_MAX;
      else dev = r_ff[SUM_W-1:0];
      dev_diff = (prior_ff >= dev) ? prior_ff - dev : dev - prior_ff;
      d1 = fdcr_pkg::digit_count(prior_ff);
      d2 = fdcr_pkg::digit_count(dev);
      d3 = fdcr_pkg::digit_count(dev_diff);
      lim = (d1 < d2) ? d1 : d2;
      rep = bcnt_ff >= period_ff;
      high = rep && (cut_ff > limit_ff);
      cut_base = rep ? '0 : cut_ff;
      cut = (prior_ff != '0) && (d3 > lim);
      cnt_ext = (CNT_W+6)'(cnt_ff);
   end

   always_comb begin
      pix_acc_in = pix_acc_ff;
      cnt_in = cnt_ff;
      total_in = total_ff;
      ovf_in = ovf_ff;
      prior_in = prior_ff;
      cut_in = cut_ff;
      bcnt_in = bcnt_ff;
      if (cmd.pix) begin
         pix_acc_in = frame_sum;
         if (frame_end) begin
            pix_acc_in = '0;
            if (store_en) begin
               cnt_in = cnt_ff + CNT_W'(1);
               total_in = total_ff + TOT_W'(frame_sum);
            end else begin
               ovf_in = 1'b1;
            end
         end
      end
      if (cmd.fin) begin
         cnt_in = '0;
         total_in = '0;
         ovf_in = 1'b0;
         prior_in = dev;
         bcnt_in = (rep ? '0 : bcnt_ff) + CW'(1);
         cut_in = (cut && cut_base != fdcr_pkg::CUT_MAX) ? cut_base + CW'(1) : cut_base;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_acc_ff <= '0;
         cnt_ff <= '0;
         total_ff <= '0;
         ovf_ff <= 1'b0;
         prior_ff <= '0;
         cut_ff <= '0;
         bcnt_ff <= '0;
         period_ff <= fdcr_pkg::REPORT_PERIOD_RST;
         limit_ff <= fdcr_pkg::HIGH_CUT_LIMIT_RST;
         rsp_valid_ff <= 1'b0;
         div_i_ff <= '0;
      end else begin
         pix_acc_ff <= pix_acc_in;
         cnt_ff <= cnt_in;
         total_ff <= total_in;
         ovf_ff <= ovf_in;
         prior_ff <= prior_in;
         cut_ff <= cut_in;
         bcnt_ff <= bcnt_in;
         if (csr_wr_en) begin
            unique case (csr_addr)
               fdcr_pkg::CFG_REPORT_PERIOD:  period_ff <= csr_wr_data;
               fdcr_pkg::CFG_HIGH_CUT_LIMIT: limit_ff <= csr_wr_data;
               default: ;
            endcase
         end
         if (cmd.fin) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         if (cmd.chk || cmd.var_init) div_i_ff <= DI_W'(ACC_W);
         else if (cmd.step) div_i_ff <= div_i_ff - DI_W'(1);
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.chk) begin
         num_ff <= ACC_W'(total_ff);
         rem_ff <= '0;
         dvs_ff <= cnt_ff;
         r_ff <= '0;
      end else if (cmd.var_init) begin
         num_ff <= sq_acc_ff;
         rem_ff <= '0;
         dvs_ff <= cnt_ff - CNT_W'(1);
      end else if (cmd.step) begin
         num_ff <= {num_ff[ACC_W-2:0], q_bit};
         rem_ff <= q_bit ? rem_sh - {1'b0, dvs_ff} : rem_sh;
      end
      if (cmd.mean_ld) begin
         mean_ff <= num_ff[SUM_W-1:0];
         idx_ff <= '0;
         sq_acc_ff <= '0;
      end
      if (cmd.df) diff_ff <= (ram_q >= mean_ff) ? ram_q - mean_ff : mean_ff - ram_q;
      if (cmd.mul) sq_ff <= diff_ff * diff_ff;
      if (cmd.acc) begin
         sq_acc_ff <= sq_acc_ff + ACC_W'(sq_ff);
         idx_ff <= idx_ff + CNT_W'(1);
      end
      if (cmd.var_ld) begin
         // quotient saturates to 64 bits
         v_ff <= ((num_ff >> RW) != '0) ? {RW{1'b1}} : num_ff[RW-1:0];
         r_ff <= '0;
         bit_ff <= RW'(1) << (RW - 2);
      end else if (cmd.root) begin
         if (v_ff >= r_plus) begin
            v_ff <= v_ff - r_plus;
            r_ff <= (r_ff >> 1) + bit_ff;
         end else begin
            r_ff <= r_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
      if (cmd.fin) begin
         rsp_ff.deviation <= dev;
         rsp_ff.cut_found <= cut;
         rsp_ff.report_valid <= rep;
         rsp_ff.high_cut_rate <= high;
         rsp_ff.frames_in_batch <= cnt_ext[fdcr_pkg::FIB_W-1:0];
         rsp_ff.batch_overflow <= ovf_ff;
      end
   end

   assign sts.small_n = cnt_ff < CNT_W'(2);
   assign sts.div_done = div_i_ff == '0;
   assign sts.loop_last = (idx_ff + CNT_W'(1)) == cnt_ff;
   assign sts.root_done = bit_ff == '0;
   assign sts.rsp_valid = rsp_valid_ff;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

// ===== hw/rtl/frame_deviation_cut_rate_detector.sv =====
// frame_deviation_cut_rate_detector: top level, controller plus datapath
// depends on fdcr_pkg, fdcr_ctrl, fdcr_datapath, fdcr_ram
//
// Pixels are taken one per cycle. A pixel that closes a batch starts the statistics
// pass, during which no pixel is taken. A batch that stores fewer than two frames
// goes straight from the check to the result. A larger batch runs two divides on
// one shared bit-serial divider (mean, then variance), each 62 + clog2(cap+1)
// steps, a squared-difference loop over the stored frames (ram read, difference,
// multiply, accumulate), 32 root steps, and the check, variance set-up and
// finish states. The result register lets pixels flow while the result waits;
// only the next batch end holds off until it is taken.
module frame_deviation_cut_rate_detector #(
   parameter int MAX_FRAMES = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  fdcr_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output fdcr_pkg::rsp_type               rsp_data,
   input  logic                            csr_wr_en,
   input  logic [fdcr_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [fdcr_pkg::CFG_W-1:0]      csr_wr_data
);

   fdcr_pkg::cmd_type cmd;
   fdcr_pkg::sts_type sts;

   fdcr_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_last_of_batch (req_data.last_of_batch),
      .req_ready         (req_ready),
      .sts               (sts),
      .cmd               (cmd)
   );

   fdcr_datapath #(.MAX_FRAMES(MAX_FRAMES)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_addr    (csr_addr),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

// ===== bench/frame_deviation_cut_rate_detector_tb.sv =====
// testbench for frame_deviation_cut_rate_detector: directed and random pixel batches checked
// against a cycle-free model of the batch statistics; depends on fdcr_pkg and the rtl
module frame_deviation_cut_rate_detector_tb;

   localparam int CAP = 32;
   localparam int SETTLE = 400;
   localparam longint CYCLE_LIMIT = 2000000;
   localparam logic [fdcr_pkg::CSR_ADDR_W-1:0] CFG_UNUSED = 2'd3;

   class batch_stats_board;
      logic [7:0]  period, limit;
      logic [30:0] pix_acc;
      logic [30:0] sums [CAP];
      int          nframes;
      logic [35:0] total;
      logic [30:0] prev_dev;
      logic [7:0]  cuts, batches;
      bit          ovf;
      fdcr_pkg::rsp_type pending [$];
      int          errors;

      function new();
         period = fdcr_pkg::REPORT_PERIOD_RST; limit = fdcr_pkg::HIGH_CUT_LIMIT_RST;
         pix_acc = 0; nframes = 0; total = 0; prev_dev = 0;
         cuts = 0; batches = 0; ovf = 0; errors = 0;
      endfunction

      function int digits(logic [31:0] x);
         int d;
         logic [31:0] t;
         d = 1; t = 10;
         while (x >= t) begin
            d++;
            if (t == 32'd1000000000) break;
            t = t * 10;
         end
         return d;
      endfunction

      function logic [63:0] root64(logic [63:0] v);
         logic [63:0] r, b;
         r = 0; b = 64'd1 << 62;
         while (b > v) b = b >> 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      function logic [30:0] deviation_of_batch();
         logic [63:0]  mean, d, var64, rt;
         logic [127:0] acc, q;
         acc = 0;
         if (nframes < 2) return 0;
         mean = total / nframes;
         for (int i = 0; i < nframes; i++) begin
            d = (sums[i] >= mean) ? sums[i] - mean : mean - sums[i];
            acc = acc + d * d;
         end
         q = acc / (nframes - 1);
         var64 = (q[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : q[63:0];
         rt = root64(var64);
         return (rt > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : rt[30:0];
      endfunction

      function void set_reg(logic [1:0] idx, logic [7:0] val);
         if (idx == fdcr_pkg::CFG_REPORT_PERIOD) period = val;
         else if (idx == fdcr_pkg::CFG_HIGH_CUT_LIMIT) limit = val;
      endfunction

      function void note_pixel(fdcr_pkg::req_type p);
         logic [31:0] px, s;
         fdcr_pkg::rsp_type r;
         logic [31:0] diff;
         int          lim;
         px = 32'(p.blue) + 32'(p.green) + 32'(p.red);
         s = pix_acc + px;
         pix_acc = (s > 32'h7FFF_FFFF) ? 31'h7FFF_FFFF : s[30:0];
         if (p.last_of_frame || p.last_of_batch) begin
            if (nframes < CAP) begin
               sums[nframes] = pix_acc;
               nframes++;
               total = total + 36'(pix_acc);
            end else begin
               ovf = 1;
            end
            pix_acc = 0;
         end
         if (!p.last_of_batch) return;
         r = '0;
         if (batches >= period) begin
            r.report_valid = 1;
            r.high_cut_rate = cuts > limit;
            batches = 0; cuts = 0;
         end
         batches = batches + 8'd1;
         r.deviation = deviation_of_batch();
         if (prev_dev != 0) begin
            diff = (prev_dev >= r.deviation) ? prev_dev - r.deviation : r.deviation - prev_dev;
            lim = digits(prev_dev) < digits(r.deviation) ? digits(prev_dev)
                                                         : digits(r.deviation);
            if (digits(diff) > lim) begin
               r.cut_found = 1;
               if (cuts != fdcr_pkg::CUT_MAX) cuts = cuts + 8'd1;
            end
         end
         prev_dev = r.deviation;
         r.frames_in_batch = nframes[5:0];
         r.batch_overflow = ovf;
         pending.push_back(r);
         nframes = 0; total = 0; ovf = 0;
      endfunction

      function void check_result(fdcr_pkg::rsp_type got);
         fdcr_pkg::rsp_type e;
         if (pending.size() == 0) begin
            $error("result with nothing expected: %p", got);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.deviation !== e.deviation) begin
            $error("deviation expected %0d actual %0d", e.deviation, got.deviation); errors++;
         end
         if (got.cut_found !== e.cut_found) begin
            $error("cut_found expected %0d actual %0d", e.cut_found, got.cut_found); errors++;
         end
         if (got.report_valid !== e.report_valid) begin
            $error("report_valid expected %0d actual %0d", e.report_valid,
                   got.report_valid); errors++;
         end
         if (got.high_cut_rate !== e.high_cut_rate) begin
            $error("high_cut_rate expected %0d actual %0d", e.high_cut_rate,
                   got.high_cut_rate); errors++;
         end
         if (got.frames_in_batch !== e.frames_in_batch) begin
            $error("frames_in_batch expected %0d actual %0d", e.frames_in_batch,
                   got.frames_in_batch); errors++;
         end
         if (got.batch_overflow !== e.batch_overflow) begin
            $error("batch_overflow expected %0d actual %0d", e.batch_overflow,
                   got.batch_overflow); errors++;
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_ready, rsp_valid, rsp_ready = 0;
   fdcr_pkg::req_type req_data = '0;
   fdcr_pkg::rsp_type rsp_data;
   logic csr_wr_en = 0;
   logic [fdcr_pkg::CSR_ADDR_W-1:0] csr_addr = '0;
   logic [fdcr_pkg::CFG_W-1:0] csr_wr_data = '0;
   longint cycles = 0;
   batch_stats_board board = new();

   frame_deviation_cut_rate_detector dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // result side: random stall before each transaction
   initial begin
      int gap;
      @(posedge clock iff !reset);
      forever begin
         gap = $urandom_range(0, 9);
         if ($urandom_range(0, 3) == 0) gap = 0;
         if (gap > 0) begin
            rsp_ready <= 0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1;
         @(posedge clock iff rsp_valid);
         board.check_result(rsp_data);
      end
   end

   task automatic send_pixel(fdcr_pkg::req_type p, bit burst);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_data <= p;
      @(posedge clock iff req_ready);
      board.note_pixel(p);
   endtask

   task automatic go_idle();
      req_valid <= 0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [7:0] val);
      csr_wr_en <= 1; csr_addr <= idx; csr_wr_data <= val;
      @(posedge clock);
      board.set_reg(idx, val);
      csr_wr_en <= 0;
      @(posedge clock);
   endtask

   function automatic fdcr_pkg::req_type rand_pixel(int mode);
      fdcr_pkg::req_type p;
      p.blue = 8'($urandom); p.green = 8'($urandom); p.red = 8'($urandom);
      if (mode == 1) begin p.blue = 8'd255; p.green = 8'd255; p.red = 8'd255; end
      if (mode == 2) begin p.blue = 8'd0; p.green = 8'd0; p.red = 8'd0; end
      p.last_of_frame = 0; p.last_of_batch = 0;
      return p;
   endfunction

   // one batch of nf frames with pl pixels per frame
   task automatic send_batch(int nf, int pl, int mode, bit burst);
      fdcr_pkg::req_type p;
      for (int f = 0; f < nf; f++)
         for (int k = 0; k < pl; k++) begin
            p = rand_pixel(mode == 3 ? $urandom_range(0, 2) : mode);
            p.last_of_frame = (k == pl - 1) && (f != nf - 1 || $urandom_range(0, 1));
            p.last_of_batch = (k == pl - 1) && (f == nf - 1);
            send_pixel(p, burst);
         end
   endtask

   initial begin
      int nf, pl;
      fdcr_pkg::req_type p;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed part
      send_batch(1, 2, 1, 0);
      send_batch(2, 2, 1, 0);
      send_batch(2, 2, 2, 0);
      send_batch(3, 2, 0, 1);
      p = rand_pixel(1); p.last_of_batch = 1; send_pixel(p, 0);
      send_batch(CAP + 2, 1, 0, 1);
      go_idle();
      write_reg(fdcr_pkg::CFG_REPORT_PERIOD, 8'd0);
      write_reg(fdcr_pkg::CFG_HIGH_CUT_LIMIT, 8'd0);
      write_reg(CFG_UNUSED, 8'hFF);
      send_batch(2, 1, 1, 0);
      send_batch(2, 1, 2, 0);
      send_batch(3, 1, 3, 0);
      go_idle();
      // random part over several register settings
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            1: begin write_reg(fdcr_pkg::CFG_REPORT_PERIOD, 8'd255);
                     write_reg(fdcr_pkg::CFG_HIGH_CUT_LIMIT, 8'd255); end
            2: begin write_reg(fdcr_pkg::CFG_REPORT_PERIOD, 8'd1);
                     write_reg(fdcr_pkg::CFG_HIGH_CUT_LIMIT, 8'd0); end
            3: begin write_reg(fdcr_pkg::CFG_REPORT_PERIOD, 8'($urandom_range(1, 8)));
                     write_reg(fdcr_pkg::CFG_HIGH_CUT_LIMIT, 8'($urandom_range(0, 3))); end
            4: begin write_reg(fdcr_pkg::CFG_REPORT_PERIOD, 8'd2);
                     write_reg(fdcr_pkg::CFG_HIGH_CUT_LIMIT, 8'd1); end
            5: begin write_reg(fdcr_pkg::CFG_REPORT_PERIOD, 8'd0);
                     write_reg(fdcr_pkg::CFG_HIGH_CUT_LIMIT, 8'd2); end
            default: ;
         endcase
         for (int b = 0; b < 22; b++) begin
            nf = ($urandom_range(0, 15) == 0) ? $urandom_range(CAP - 1, CAP + 3)
                                                : $urandom_range(1, 5);
            pl = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(1, 4);
            send_batch(nf, pl, $urandom_range(0, 3), $urandom_range(0, 2) == 0);
         end
         go_idle();
      end
      if (board.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

// ===== files.f =====
hw/rtl/fdcr_pkg.sv
hw/rtl/fdcr_ram.sv
hw/rtl/fdcr_ctrl.sv
hw/rtl/fdcr_datapath.sv
hw/rtl/frame_deviation_cut_rate_detector.sv
bench/frame_deviation_cut_rate_detector_tb.sv
